// ===== hdl/block_average_luma_to_glyph_unit_assert.svh =====
// Assertion macros shared by the checker of the luma-to-glyph unit.
`ifndef BLOCK_AVERAGE_LUMA_TO_GLYPH_UNIT_ASSERT_SVH
`define BLOCK_AVERAGE_LUMA_TO_GLYPH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BALG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BALG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/balg_pkg.sv =====
// Shared types and constants of the luma-to-glyph unit.
`default_nettype none
package balg_pkg;
   localparam int MAX_SRC_W  = 256;
   localparam int MAX_SRC_H  = 256;
   localparam int MAX_CELLS  = 1024;
   localparam int MAX_GLYPHS = 16;
   localparam int SRC_X_BITS = 8;
   localparam int SRC_Y_BITS = 8;
   localparam int DIVIDEND_W = 26;
   localparam int DIVISOR_W  = 22;
   localparam logic [21:0] LUMA_FULL = 22'd2550000;
   localparam logic OPER_WRITE = 1'b0;
   localparam logic OPER_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_LAUNCH, ST_DIV_WAIT, ST_REGION, ST_SUM_START,
      ST_SUM, ST_SUM_DRAIN, ST_LUMA, ST_SCALE, ST_INDEX, ST_OUTPUT
   } state_type;

   typedef enum logic [2:0] {
      OP_X0, OP_X1, OP_Y0, OP_Y1, OP_R, OP_G, OP_B
   } div_op_type;

   typedef enum logic [2:0] {
      CSR_SRC_W, CSR_SRC_H, CSR_CELLS_X, CSR_CELLS_Y,
      CSR_INVERT, CSR_GLYPH_CNT, CSR_GLYPHS_LO, CSR_GLYPHS_HI
   } csr_index_type;
endpackage
`default_nettype wire

// ===== hdl/balg_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module balg_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [balg_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [balg_pkg::DIVISOR_W-1:0]  divisor,
   output logic                                  done,
   output logic [balg_pkg::DIVIDEND_W-1:0]       quotient
);
   import balg_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;
   logic [DIVISOR_W:0]    diff;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== hdl/block_average_luma_to_glyph_unit.sv =====
// Top level: frame store, query sequencer and glyph selection.
// A pixel write leaves the block ready again at once.
// A query result follows 7 divisions, N reads of the source pixels of the cell region and
// an index search up to the glyph index.
// The block takes no item while a query runs; a stalled result holds it in the output state.
// Synchronous reset defaults state, result valid and CSRs; the frame store is not cleared.
`default_nettype none
module block_average_luma_to_glyph_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // column[9:0], row[19:10], red_in[27:20], green_in[35:28], blue_in[43:36]
   input  wire logic [47:0] req_tdata,
   // operation[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // glyph[7:0], glyph_index[11:8], mean_red[19:12], mean_green[27:20],
   // mean_blue[35:28]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import balg_pkg::*;

   localparam int ADDR_W = SRC_X_BITS + SRC_Y_BITS;

   state_type state_ff, state_in;
   div_op_type op_ff;

   logic [8:0]  src_w_ff, src_h_ff;
   logic [10:0] cells_x_ff, cells_y_ff;
   logic        invert_ff;
   logic [4:0]  glyph_cnt_ff;
   logic [63:0] glyphs_lo_ff, glyphs_hi_ff;

   logic [8:0]  eff_w, eff_h;
   logic [10:0] eff_ow, eff_oh;
   logic [4:0]  eff_len;
   logic [3:0]  len_m1;

   logic [9:0]  in_col, in_row;
   logic [23:0] in_rgb;
   logic        req_fire, query_ok;

   logic [9:0]  col_ff, row_ff;
   logic [8:0]  x0_ff, x1_ff, y0_ff, y1_ff;
   logic [SRC_X_BITS-1:0] x_ff;
   logic [SRC_Y_BITS-1:0] y_ff;
   logic        x_last, y_last;
   logic [16:0] cnt_ff;
   logic [17:0] cnt_calc;
   logic [23:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic        rd_valid_ff;
   logic [23:0] rd_data_ff;
   logic [23:0] frame_mem [0:(1 << ADDR_W)-1];

   logic [7:0]  mean_r_ff, mean_g_ff, mean_b_ff;
   logic [1:0]  luma_step_ff;
   logic [21:0] luma_ff;
   logic [20:0] luma_term;
   logic [21:0] luma_adj;
   logic [DIVIDEND_W-1:0] scaled_ff;
   logic [DIVIDEND_W-1:0] thresh_ff;
   logic [3:0]  idx_ff;

   logic        div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [18:0] prod_lo_x, prod_lo_y;
   logic [19:0] prod_hi_x, prod_hi_y;

   logic        rsp_load;
   logic        rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;
   logic [127:0] glyph_bank;
   logic [7:0]  glyph_byte;

   assign eff_w   = (src_w_ff == 9'd0) ? 9'd1 :
                    (src_w_ff > 9'(MAX_SRC_W)) ? 9'(MAX_SRC_W) : src_w_ff;
   assign eff_h   = (src_h_ff == 9'd0) ? 9'd1 :
                    (src_h_ff > 9'(MAX_SRC_H)) ? 9'(MAX_SRC_H) : src_h_ff;
   assign eff_ow  = (cells_x_ff == 11'd0) ? 11'd1 :
                    (cells_x_ff > 11'(MAX_CELLS)) ? 11'(MAX_CELLS) : cells_x_ff;
   assign eff_oh  = (cells_y_ff == 11'd0) ? 11'd1 :
                    (cells_y_ff > 11'(MAX_CELLS)) ? 11'(MAX_CELLS) : cells_y_ff;
   assign eff_len = (glyph_cnt_ff == 5'd0) ? 5'd1 :
                    (glyph_cnt_ff > 5'(MAX_GLYPHS)) ? 5'(MAX_GLYPHS) : glyph_cnt_ff;
   assign len_m1  = 4'(eff_len - 5'd1);

   assign in_col   = req_tdata[9:0];
   assign in_row   = req_tdata[19:10];
   assign in_rgb   = {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36]};
   assign req_fire = req_tvalid && req_tready;
   assign query_ok = ({1'b0, in_col} < eff_ow) && ({1'b0, in_row} < eff_oh);

   assign x_last = ({1'b0, x_ff} + 9'd1) == x1_ff;
   assign y_last = ({1'b0, y_ff} + 9'd1) == y1_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff     <= 9'd256;
         src_h_ff     <= 9'd256;
         cells_x_ff   <= 11'd100;
         cells_y_ff   <= 11'd50;
         invert_ff    <= 1'b0;
         glyph_cnt_ff <= 5'd9;
         glyphs_lo_ff <= 64'h2523_2A2B_3D2D_3A2E;
         glyphs_hi_ff <= 64'h40;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SRC_W:     src_w_ff     <= csr_data[8:0];
            CSR_SRC_H:     src_h_ff     <= csr_data[8:0];
            CSR_CELLS_X:   cells_x_ff   <= csr_data[10:0];
            CSR_CELLS_Y:   cells_y_ff   <= csr_data[10:0];
            CSR_INVERT:    invert_ff    <= csr_data[0];
            CSR_GLYPH_CNT: glyph_cnt_ff <= csr_data[4:0];
            CSR_GLYPHS_LO: glyphs_lo_ff <= csr_data;
            CSR_GLYPHS_HI: glyphs_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == OPER_WRITE &&
          {1'b0, in_col} < eff_w && {1'b0, in_row} < eff_h) begin
         frame_mem[{in_row[SRC_Y_BITS-1:0], in_col[SRC_X_BITS-1:0]}] <= in_rgb;
      end
      rd_data_ff <= frame_mem[{y_ff, x_ff}];
   end

   balg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_fire && req_tuser == OPER_QUERY && query_ok) state_in = ST_DIV_LAUNCH;
         ST_DIV_LAUNCH: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:
            if (div_done) begin
               case (op_ff)
                  OP_Y1:   state_in = ST_REGION;
                  OP_B:    state_in = ST_LUMA;
                  default: state_in = ST_DIV_LAUNCH;
               endcase
            end
         ST_REGION:    state_in = ST_SUM_START;
         ST_SUM_START: state_in = ST_SUM;
         ST_SUM:       if (x_last && y_last) state_in = ST_SUM_DRAIN;
         ST_SUM_DRAIN: state_in = ST_DIV_LAUNCH;
         ST_LUMA:      if (luma_step_ff == 2'd2) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_INDEX;
         ST_INDEX:
            if (scaled_ff < thresh_ff || idx_ff == len_m1) state_in = ST_OUTPUT;
         ST_OUTPUT:    if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   assign prod_lo_x = col_ff * eff_w;
   assign prod_hi_x = ({1'b0, col_ff} + 11'd1) * eff_w;
   assign prod_lo_y = row_ff * eff_h;
   assign prod_hi_y = ({1'b0, row_ff} + 11'd1) * eff_h;

   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      div_dividend = DIVIDEND_W'(prod_lo_x);
      div_divisor  = DIVISOR_W'(eff_ow);
      case (op_ff)
         OP_X0: begin
            div_dividend = DIVIDEND_W'(prod_lo_x);
            div_divisor  = DIVISOR_W'(eff_ow);
         end
         OP_X1: begin
            div_dividend = DIVIDEND_W'(prod_hi_x);
            div_divisor  = DIVISOR_W'(eff_ow);
         end
         OP_Y0: begin
            div_dividend = DIVIDEND_W'(prod_lo_y);
            div_divisor  = DIVISOR_W'(eff_oh);
         end
         OP_Y1: begin
            div_dividend = DIVIDEND_W'(prod_hi_y);
            div_divisor  = DIVISOR_W'(eff_oh);
         end
         OP_R: begin
            div_dividend = DIVIDEND_W'(sum_r_ff);
            div_divisor  = DIVISOR_W'(cnt_ff);
         end
         OP_G: begin
            div_dividend = DIVIDEND_W'(sum_g_ff);
            div_divisor  = DIVISOR_W'(cnt_ff);
         end
         OP_B: begin
            div_dividend = DIVIDEND_W'(sum_b_ff);
            div_divisor  = DIVISOR_W'(cnt_ff);
         end
         default: ;
      endcase
      case (state_ff)
         ST_IDLE:       req_tready = 1'b1;
         ST_DIV_LAUNCH: div_start  = 1'b1;
         ST_OUTPUT:     rsp_load   = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      case (luma_step_ff)
         2'd0:    luma_term = 21'd2126 * 21'(mean_r_ff);
         2'd1:    luma_term = 21'd7152 * 21'(mean_g_ff);
         default: luma_term = 21'd722 * 21'(mean_b_ff);
      endcase
   end

   assign luma_adj = invert_ff ? (LUMA_FULL - luma_ff) : luma_ff;
   assign cnt_calc = (x1_ff - x0_ff) * (y1_ff - y0_ff);

   always_ff @(posedge clock) begin
      rd_valid_ff <= (state_ff == ST_SUM);
      case (state_ff)
         ST_IDLE: begin
            col_ff <= in_col;
            row_ff <= in_row;
            op_ff  <= OP_X0;
         end
         ST_DIV_WAIT:
            if (div_done) begin
               case (op_ff)
                  OP_X0:   x0_ff     <= div_quotient[8:0];
                  OP_X1:   x1_ff     <= div_quotient[8:0];
                  OP_Y0:   y0_ff     <= div_quotient[8:0];
                  OP_Y1:   y1_ff     <= div_quotient[8:0];
                  OP_R:    mean_r_ff <= div_quotient[7:0];
                  OP_G:    mean_g_ff <= div_quotient[7:0];
                  OP_B:    mean_b_ff <= div_quotient[7:0];
                  default: ;
               endcase
               if (op_ff != OP_B) op_ff <= div_op_type'(op_ff + 3'd1);
               luma_ff      <= '0;
               luma_step_ff <= '0;
            end
         ST_REGION: begin
            if (x1_ff <= x0_ff) begin
               if (x0_ff < eff_w) begin
                  x1_ff <= x0_ff + 9'd1;
               end else begin
                  x0_ff <= eff_w - 9'd1;
                  x1_ff <= eff_w;
               end
            end
            if (y1_ff <= y0_ff) begin
               if (y0_ff < eff_h) begin
                  y1_ff <= y0_ff + 9'd1;
               end else begin
                  y0_ff <= eff_h - 9'd1;
                  y1_ff <= eff_h;
               end
            end
         end
         ST_SUM_START: begin
            cnt_ff   <= cnt_calc[16:0];
            x_ff     <= x0_ff[SRC_X_BITS-1:0];
            y_ff     <= y0_ff[SRC_Y_BITS-1:0];
            sum_r_ff <= '0;
            sum_g_ff <= '0;
            sum_b_ff <= '0;
         end
         ST_SUM:
            if (x_last) begin
               x_ff <= x0_ff[SRC_X_BITS-1:0];
               y_ff <= y_ff + 1'b1;
            end else begin
               x_ff <= x_ff + 1'b1;
            end
         ST_LUMA: begin
            luma_ff      <= luma_ff + 22'(luma_term);
            luma_step_ff <= luma_step_ff + 2'd1;
         end
         ST_SCALE: begin
            scaled_ff <= DIVIDEND_W'(luma_adj) * DIVIDEND_W'(len_m1);
            idx_ff    <= '0;
            thresh_ff <= DIVIDEND_W'(LUMA_FULL);
         end
         ST_INDEX:
            if (scaled_ff >= thresh_ff && idx_ff != len_m1) begin
               idx_ff    <= idx_ff + 4'd1;
               thresh_ff <= thresh_ff + DIVIDEND_W'(LUMA_FULL);
            end
         default: ;
      endcase
      if (rd_valid_ff) begin
         sum_r_ff <= sum_r_ff + 24'(rd_data_ff[23:16]);
         sum_g_ff <= sum_g_ff + 24'(rd_data_ff[15:8]);
         sum_b_ff <= sum_b_ff + 24'(rd_data_ff[7:0]);
      end
   end

   assign glyph_bank = {glyphs_hi_ff, glyphs_lo_ff};
   assign glyph_byte = glyph_bank[{idx_ff, 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {4'd0, mean_b_ff, mean_g_ff, mean_r_ff, idx_ff, glyph_byte};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule
`default_nettype wire

// ===== hdl/balg_checker.sv =====
// Port-level checker of the luma-to-glyph unit and its bind.
`default_nettype none
`include "block_average_luma_to_glyph_unit_assert.svh"
module balg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import balg_pkg::*;

   `BALG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `BALG_ASSERT_NEXT(a_write_ready, clock, reset, req_tvalid && req_tready && req_tuser == OPER_WRITE, req_tready, "not ready after a pixel write")
   `BALG_ASSERT_SAME(a_result_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while idle")
endmodule

bind block_average_luma_to_glyph_unit balg_checker u_balg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
